[sv/ocs_pkg.sv]
// Shared widths, register map, reset values and configuration type of the op-amp step core.
package ocs_pkg;

    localparam int GAIN_W        = 20;
    localparam int FIELD_W       = 31;
    localparam int VD_W          = 32;
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;
    localparam int REG_IDX_W     = 2;
    localparam int VOLT_BITS_DEF = 32;
    localparam int CONV_TOL      = 5;

    localparam logic [REG_IDX_W-1:0] REG_GAIN       = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_USE_SUPPLY = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RAIL_HIGH  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_RAIL_LOW   = 2'd3;

    localparam logic [GAIN_W-1:0]  GAIN_RST      = 20'd1000;
    localparam logic [FIELD_W-1:0] RAIL_HIGH_RST = 31'd5000000;
    localparam logic [FIELD_W-1:0] RAIL_LOW_RST  = 31'd0;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic               use_supply;
        logic [FIELD_W-1:0] rail_high;
        logic [FIELD_W-1:0] rail_low;
    } cfg_t;

endpackage

[sv/ocs_regs.sv]
// APB configuration registers of the op-amp step core.
module ocs_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ocs_pkg::PADDR_W-1:0] paddr,
    input  logic [ocs_pkg::PDATA_W-1:0] pwdata,
    output logic [ocs_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output ocs_pkg::cfg_t               cfg
);

    logic [ocs_pkg::GAIN_W-1:0]    gain_reg;
    logic                          use_supply_reg;
    logic [ocs_pkg::FIELD_W-1:0]   rail_high_reg;
    logic [ocs_pkg::FIELD_W-1:0]   rail_low_reg;
    logic [ocs_pkg::REG_IDX_W-1:0] idx;
    logic                          wr_en;

    assign idx    = paddr[ocs_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg       <= ocs_pkg::GAIN_RST;
            use_supply_reg <= 1'b0;
            rail_high_reg  <= ocs_pkg::RAIL_HIGH_RST;
            rail_low_reg   <= ocs_pkg::RAIL_LOW_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ocs_pkg::REG_GAIN:       gain_reg       <= pwdata[ocs_pkg::GAIN_W-1:0];
                ocs_pkg::REG_USE_SUPPLY: use_supply_reg <= pwdata[0];
                ocs_pkg::REG_RAIL_HIGH:  rail_high_reg  <= pwdata[ocs_pkg::FIELD_W-1:0];
                ocs_pkg::REG_RAIL_LOW:   rail_low_reg   <= pwdata[ocs_pkg::FIELD_W-1:0];
                default:                 gain_reg       <= gain_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ocs_pkg::REG_GAIN:       prdata = ocs_pkg::PDATA_W'(gain_reg);
            ocs_pkg::REG_USE_SUPPLY: prdata = ocs_pkg::PDATA_W'(use_supply_reg);
            ocs_pkg::REG_RAIL_HIGH:  prdata = ocs_pkg::PDATA_W'($signed(rail_high_reg));
            ocs_pkg::REG_RAIL_LOW:   prdata = ocs_pkg::PDATA_W'($signed(rail_low_reg));
            default:                 prdata = '0;
        endcase
    end

    assign cfg.gain       = gain_reg;
    assign cfg.use_supply = use_supply_reg;
    assign cfg.rail_high  = rail_high_reg;
    assign cfg.rail_low   = rail_low_reg;

endmodule

[sv/ocs_mul.sv]
// Shift-and-add multiplier that retires one bit of the unsigned multiplier per cycle.
module ocs_mul #(
    parameter int A_W      = 32,
    parameter int B_W      = 20,
    parameter bit A_SIGNED = 1'b1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [A_W-1:0]   a,
    input  logic [B_W-1:0]   b,
    output logic             done,
    output logic [A_W+B_W-1:0] p
);

    localparam int P_W = A_W + B_W;
    localparam int CW  = $clog2(B_W);

    logic [A_W-1:0] a_reg;
    logic [P_W-1:0] acc_reg;
    logic [P_W-1:0] acc_next;
    logic           busy_reg;
    logic [CW-1:0]  cnt_reg;
    logic [A_W-1:0] hi;
    logic [A_W:0]   addend;
    logic [A_W:0]   sum;

    // The multiplier bits sit in the low end of the accumulator and shift out as the
    // product shifts in from the top.
    assign hi       = acc_reg[P_W-1:B_W];
    assign addend   = acc_reg[0] ? {A_SIGNED & a_reg[A_W-1], a_reg} : '0;
    assign sum      = {A_SIGNED & hi[A_W-1], hi} + addend;
    assign acc_next = {sum, acc_reg[B_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            cnt_reg  <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            acc_reg <= P_W'(b);
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = busy_reg && (cnt_reg == CW'(B_W - 1));
    assign p    = acc_reg;

endmodule

[sv/ocs_div.sv]
// Restoring divider that produces one quotient bit per cycle, most significant first.
module ocs_div #(
    parameter int N_W = 53,
    parameter int D_W = 52
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CW = $clog2(N_W);

    logic [N_W-1:0] q_reg;
    logic [D_W-1:0] rem_reg;
    logic [D_W-1:0] dvs_reg;
    logic           busy_reg;
    logic [CW-1:0]  cnt_reg;
    logic [D_W:0]   trial;
    logic [D_W+1:0] diff;
    logic           take;

    assign trial = {rem_reg, q_reg[N_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign take  = !diff[D_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            cnt_reg  <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // The remainder never reaches the divisor, so it always fits D_W bits.
            rem_reg <= take ? diff[D_W-1:0] : trial[D_W-1:0];
            q_reg   <= {q_reg[N_W-2:0], take};
        end
    end

    assign done     = busy_reg && (cnt_reg == CW'(N_W - 1));
    assign quotient = q_reg;

endmodule

[sv/opamp_convergence_step_core.sv]
// Top level of the op-amp output step core: sequencer, state and serial arithmetic units.
//
//  Channel  Signals                                        Direction  Moves
//  in       in_valid/in_ready, v_plus, v_minus,            into core  one request per step
//           supply_high, supply_low
//  out      out_valid/out_ready, converged, drive_volt     out        one result per request
//  cfg      psel, penable, pwrite, paddr, pwdata, prdata   both       register access
//
// After acceptance the core forms the difference, runs both gain multiplies and clamps the
// target; it loads the held drive on convergence, else a clamped probe, direct guess or
// secant step. The gain multiply takes one gain bit at a time; the divider takes one quotient
// bit per cycle over the numerator, 53 bits for VOLT_BITS up to 52. A new request is taken
// only when the core is idle; a finished result sits in the output register, so the next
// request may be taken while it waits. Reset clears the solver state.
module opamp_convergence_step_core #(
    parameter int VOLT_BITS = ocs_pkg::VOLT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ocs_pkg::PADDR_W-1:0]        paddr,
    input  logic [ocs_pkg::PDATA_W-1:0]        pwdata,
    output logic [ocs_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [ocs_pkg::FIELD_W-1:0] v_plus,
    input  logic signed [ocs_pkg::FIELD_W-1:0] v_minus,
    input  logic signed [ocs_pkg::FIELD_W-1:0] supply_high,
    input  logic signed [ocs_pkg::FIELD_W-1:0] supply_low,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               converged,
    output logic signed [ocs_pkg::FIELD_W-1:0] drive_volt
);

    localparam int FW    = ocs_pkg::FIELD_W;
    localparam int GW    = ocs_pkg::GAIN_W;
    localparam int VDW   = ocs_pkg::VD_W;
    localparam int VW    = VOLT_BITS;
    localparam int MW    = (VW > VDW) ? VW : VDW;
    localparam int SUB_W = MW + 1;
    localparam int D_W   = MW;
    localparam int DEN_W = D_W + GW;
    localparam int TW    = VDW + GW;
    localparam int NUM_W = ((TW > VW) ? TW : VW) + 1;
    localparam int DRV_W = NUM_W + 2;
    localparam int CD_W  = MW + 1;

    localparam logic signed [MW-1:0]   VMAX    = {{(MW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [MW-1:0]   VMIN    = ~VMAX;
    localparam logic signed [CD_W-1:0] TOL_POS = CD_W'(ocs_pkg::CONV_TOL);
    localparam logic signed [CD_W-1:0] TOL_NEG = -TOL_POS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_MST   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_TGT   = 4'd4;
    localparam logic [3:0] S_DEC   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_QADD  = 4'd7;
    localparam logic [3:0] S_CLAMP = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    ocs_pkg::cfg_t cfg;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic                     probe_reg;
    logic signed [VW-1:0]     prev_diff_reg;
    logic signed [VW-1:0]     prev_drive_reg;
    logic                     out_valid_reg;
    logic                     converged_reg;
    logic signed [FW-1:0]     drive_out_reg;

    logic signed [VDW-1:0]    vd_reg;
    logic signed [FW-1:0]     hi_reg;
    logic signed [FW-1:0]     lo_reg;
    logic [D_W-1:0]           d_reg;
    logic                     eq_reg;
    logic signed [FW-1:0]     tgt_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     conv_reg;
    logic signed [DRV_W-1:0]  pre_reg;
    logic signed [FW-1:0]     drv_reg;

    logic                     in_acc;
    logic                     out_load;
    logic                     mul_start;
    logic                     mul_v_done;
    logic                     mul_d_done;
    logic [TW-1:0]            mul_v_p;
    logic [DEN_W-1:0]         mul_d_p;
    logic signed [TW-1:0]     gv;
    logic                     div_start;
    logic                     div_done;
    logic [NUM_W-1:0]         div_q;
    logic [NUM_W-1:0]         num_mag;
    logic                     num_neg;

    logic signed [SUB_W-1:0]  diff_a;
    logic signed [SUB_W-1:0]  diff_b;
    logic signed [CD_W-1:0]   cdiff;
    logic                     near;
    logic                     conv;
    logic                     vd_pos;
    logic signed [DRV_W-1:0]  pd_drv;
    logic signed [DRV_W-1:0]  q_ext;
    logic signed [MW-1:0]     vd_e;
    logic signed [MW-1:0]     drv_e;
    logic signed [MW-1:0]     pd_e;
    logic signed [MW-1:0]     sat_vd;
    logic signed [MW-1:0]     sat_drv;

    ocs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ocs_mul #(.A_W(VDW), .B_W(GW), .A_SIGNED(1'b1)) u_mul_v (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (vd_reg),
        .b     (cfg.gain),
        .done  (mul_v_done),
        .p     (mul_v_p)
    );

    ocs_mul #(.A_W(D_W), .B_W(GW), .A_SIGNED(1'b0)) u_mul_d (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (d_reg),
        .b     (cfg.gain),
        .done  (mul_d_done),
        .p     (mul_d_p)
    );

    ocs_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign mul_start  = (state_reg == S_MST);
    assign gv         = mul_v_p;

    assign diff_a  = SUB_W'(prev_diff_reg) - SUB_W'(vd_reg);
    assign diff_b  = SUB_W'(vd_reg) - SUB_W'(prev_diff_reg);

    assign cdiff   = CD_W'(tgt_reg) - CD_W'(prev_drive_reg);
    assign near    = (cdiff > TOL_NEG) && (cdiff < TOL_POS);
    assign conv    = !probe_reg && (d_reg < D_W'(ocs_pkg::CONV_TOL)) && near;
    assign vd_pos  = !vd_reg[VDW-1] && (vd_reg != '0);
    assign pd_drv  = DRV_W'(prev_drive_reg);

    // The secant step divides magnitudes and puts the sign back when adding to the drive.
    assign num_neg   = num_reg[NUM_W-1];
    assign num_mag   = num_neg ? -num_reg : num_reg;
    assign div_start = (state_reg == S_DEC) && !conv && probe_reg && !eq_reg;
    assign q_ext     = DRV_W'(div_q);

    assign vd_e    = MW'(vd_reg);
    assign drv_e   = MW'(drv_reg);
    assign pd_e    = MW'(prev_drive_reg);
    assign sat_vd  = (vd_e > VMAX) ? VMAX : ((vd_e < VMIN) ? VMIN : vd_e);
    assign sat_drv = (drv_e > VMAX) ? VMAX : ((drv_e < VMIN) ? VMIN : drv_e);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_DIFF;
            S_DIFF:  state_next = S_MST;
            S_MST:   state_next = S_MUL;
            S_MUL:   if (mul_v_done && mul_d_done) state_next = S_TGT;
            S_TGT:   state_next = S_DEC;
            S_DEC:
            begin
                if (conv)
                    state_next = S_OUT;
                else if (!probe_reg || eq_reg)
                    state_next = S_CLAMP;
                else
                    state_next = S_DIV;
            end
            S_DIV:   if (div_done) state_next = S_QADD;
            S_QADD:  state_next = S_CLAMP;
            S_CLAMP: state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            probe_reg      <= 1'b0;
            prev_diff_reg  <= '0;
            prev_drive_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (out_load && !conv_reg)
            begin
                probe_reg      <= !probe_reg;
                prev_diff_reg  <= sat_vd[VW-1:0];
                prev_drive_reg <= sat_drv[VW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            vd_reg <= VDW'(v_plus) - VDW'(v_minus);
            hi_reg <= cfg.use_supply ? supply_high : $signed(cfg.rail_high);
            lo_reg <= cfg.use_supply ? supply_low  : $signed(cfg.rail_low);
        end

        if (state_reg == S_DIFF)
        begin
            d_reg  <= diff_a[SUB_W-1] ? diff_b[D_W-1:0] : diff_a[D_W-1:0];
            eq_reg <= (diff_a == '0);
        end

        if (state_reg == S_TGT)
        begin
            if (gv > TW'(hi_reg))
                tgt_reg <= hi_reg;
            else if (gv < TW'(lo_reg))
                tgt_reg <= lo_reg;
            else
                tgt_reg <= gv[FW-1:0];
            num_reg <= NUM_W'(gv) - NUM_W'(prev_drive_reg);
            den_reg <= mul_d_p + DEN_W'(1);
        end

        if (state_reg == S_DEC)
        begin
            conv_reg <= conv;
            if (!probe_reg)
                pre_reg <= vd_pos ? (pd_drv + DRV_W'(1)) : (pd_drv - DRV_W'(1));
            else
                pre_reg <= DRV_W'(tgt_reg);
        end

        if (state_reg == S_QADD)
            pre_reg <= num_neg ? (pd_drv - q_ext) : (pd_drv + q_ext);

        if (state_reg == S_CLAMP)
        begin
            if (pre_reg >= DRV_W'(hi_reg))
                drv_reg <= hi_reg;
            else if (pre_reg <= DRV_W'(lo_reg))
                drv_reg <= lo_reg;
            else
                drv_reg <= pre_reg[FW-1:0];
        end

        if (out_load)
        begin
            converged_reg <= conv_reg;
            drive_out_reg <= conv_reg ? pd_e[FW-1:0] : sat_drv[FW-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign converged  = converged_reg;
    assign drive_volt = drive_out_reg;

endmodule

[sv/ocs_chk.sv]
// Port-level checker of the op-amp step core, bound to the top level.
module ocs_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        converged,
    input logic [ocs_pkg::FIELD_W-1:0] drive_volt
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(converged) && $stable(drive_volt))
        else $error("result changed or dropped while stalled");

    // The core works on one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while the previous one is still in progress");

    // A fresh result only appears at the end of a request's work.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while the core was idle");

    // Returning to idle always leaves a result in the output register.
    a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("core went idle without presenting a result");

endmodule

bind opamp_convergence_step_core ocs_chk u_chk (.*);

[sim/opamp_convergence_step_core_tb.sv]
// Self-checking testbench of the op-amp output step core: corner items, then random loops.
module opamp_convergence_step_core_tb;

    localparam int FIELD_W  = ocs_pkg::FIELD_W;
    localparam int GAIN_W   = ocs_pkg::GAIN_W;
    localparam int PADDR_W  = ocs_pkg::PADDR_W;
    localparam int PDATA_W  = ocs_pkg::PDATA_W;
    localparam int CONV_TOL = ocs_pkg::CONV_TOL;

    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int DRAIN_CYCLES    = 120;
    localparam int MAX_REPORTS     = 10;

    localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    typedef struct {
        logic                      converged;
        logic signed [FIELD_W-1:0] drive;
    } step_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic signed [FIELD_W-1:0] v_plus;
    logic signed [FIELD_W-1:0] v_minus;
    logic signed [FIELD_W-1:0] supply_high;
    logic signed [FIELD_W-1:0] supply_low;
    logic out_valid;
    logic out_ready;
    logic converged;
    logic signed [FIELD_W-1:0] drive_volt;

    // Solver state and register copy held by the predictor.
    ocs_pkg::cfg_t core_cfg = '{gain: ocs_pkg::GAIN_RST, use_supply: 1'b0,
                                rail_high: ocs_pkg::RAIL_HIGH_RST,
                                rail_low: ocs_pkg::RAIL_LOW_RST};
    bit      probe_armed = 1'b0;
    longint  last_diff   = 0;
    longint  last_drive  = 0;

    step_result_t pending_drives[$];
    step_result_t head;
    int errors         = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    opamp_convergence_step_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .v_plus      (v_plus),
        .v_minus     (v_minus),
        .supply_high (supply_high),
        .supply_low  (supply_low),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .converged   (converged),
        .drive_volt  (drive_volt)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic longint abs_gap(input longint a, input longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Advances the solver by one request and returns the result the core must give.
    // At the default VOLT_BITS of 32 neither the difference nor the clamped drive can
    // leave the stored range, so no saturation is applied.
    function automatic step_result_t next_drive_step(
        input logic signed [FIELD_W-1:0] vp,
        input logic signed [FIELD_W-1:0] vn,
        input logic signed [FIELD_W-1:0] sh,
        input logic signed [FIELD_W-1:0] sl
    );
        longint hi;
        longint lo;
        longint gain_l;
        longint vd;
        longint target;
        longint drive;
        longint spread;
        step_result_t res;
        hi = core_cfg.use_supply ? longint'(sh) : longint'($signed(core_cfg.rail_high));
        lo = core_cfg.use_supply ? longint'(sl) : longint'($signed(core_cfg.rail_low));
        gain_l = longint'(core_cfg.gain);
        vd = longint'(vp) - longint'(vn);
        target = gain_l * vd;
        if (target > hi)
            target = hi;
        else if (target < lo)
            target = lo;

        if (!probe_armed && abs_gap(last_diff, vd) < CONV_TOL
            && abs_gap(target, last_drive) < CONV_TOL)
        begin
            res.converged = 1'b1;
            res.drive = FIELD_W'(last_drive);
            return res;
        end

        if (!probe_armed)
        begin
            drive = last_drive + ((vd > 0) ? 1 : -1);
            probe_armed = 1'b1;
        end
        else
        begin
            drive = target;
            if (last_diff != vd)
            begin
                spread = abs_gap(last_diff, vd);
                drive = last_drive + (gain_l * vd - last_drive) / (gain_l * spread + 1);
            end
            probe_armed = 1'b0;
        end

        // The same comparison order holds when the rails are inverted.
        if (drive >= hi)
            drive = hi;
        else if (drive <= lo)
            drive = lo;

        last_diff = vd;
        last_drive = drive;
        res.converged = 1'b0;
        res.drive = FIELD_W'(drive);
        return res;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch in %s: expected %0d, got %0d", what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_drives.size() == 0)
                note_mismatch("result with no request outstanding", 0, drive_volt);
            else
            begin
                head = pending_drives.pop_front();
                if (converged !== head.converged)
                    note_mismatch("converged", head.converged, converged);
                if (drive_volt !== head.drive)
                    note_mismatch("drive_volt", head.drive, drive_volt);
            end
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
    endtask

    // Sends one request. Valid is left high after acceptance so that back-to-back
    // requests never lower and raise it within one time step.
    task automatic send_step(
        input logic signed [FIELD_W-1:0] vp,
        input logic signed [FIELD_W-1:0] vn,
        input logic signed [FIELD_W-1:0] sh,
        input logic signed [FIELD_W-1:0] sl
    );
        if (send_idle_pct != 0)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        v_plus      <= vp;
        v_minus     <= vn;
        supply_high <= sh;
        supply_low  <= sl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_drives.push_back(next_drive_step(vp, vn, sh, sl));
    endtask

    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Writes a register, then reads it back over the same port.
    task automatic write_reg(
        input logic [ocs_pkg::REG_IDX_W-1:0] idx,
        input logic [PDATA_W-1:0]            value
    );
        logic [PDATA_W-1:0] mask;
        case (idx)
            ocs_pkg::REG_GAIN:
            begin
                core_cfg.gain = value[GAIN_W-1:0];
                mask = {{(PDATA_W-GAIN_W){1'b0}}, {GAIN_W{1'b1}}};
            end
            ocs_pkg::REG_USE_SUPPLY:
            begin
                core_cfg.use_supply = value[0];
                mask = {{(PDATA_W-1){1'b0}}, 1'b1};
            end
            ocs_pkg::REG_RAIL_HIGH:
            begin
                core_cfg.rail_high = value[FIELD_W-1:0];
                mask = {{(PDATA_W-FIELD_W){1'b0}}, {FIELD_W{1'b1}}};
            end
            default:
            begin
                core_cfg.rail_low = value[FIELD_W-1:0];
                mask = {{(PDATA_W-FIELD_W){1'b0}}, {FIELD_W{1'b1}}};
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if ((prdata & mask) !== (value & mask))
            note_mismatch("register read-back", value & mask, prdata & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [FIELD_W-1:0] rand_field();
        return FIELD_W'($urandom);
    endfunction

    function automatic logic signed [FIELD_W-1:0] rand_span(input int unsigned span);
        return FIELD_W'(longint'($urandom_range(0, 2 * span)) - longint'(span));
    endfunction

    function automatic logic signed [FIELD_W-1:0] pick_voltage();
        case ($urandom_range(0, 3))
            0: return rand_span(2000);
            1: return rand_span(2_000_000);
            2: return rand_span(1_000_000_000);
            default: return rand_field();
        endcase
    endfunction

    // Mostly zero, now and then a few microvolts either side of the tolerance.
    function automatic int small_jitter();
        if ($urandom_range(0, 3) == 0)
            return int'($urandom_range(0, 12)) - 6;
        return 0;
    endfunction

    task automatic pick_rails(
        input int kind,
        output logic signed [FIELD_W-1:0] hi,
        output logic signed [FIELD_W-1:0] lo
    );
        case (kind)
            0:
            begin
                hi = FIELD_W'($urandom_range(0, 5_000_000));
                lo = -FIELD_W'($urandom_range(0, 5_000_000));
            end
            1:
            begin
                hi = FIELD_MAX;
                lo = FIELD_MIN;
            end
            2:
            begin
                hi = -FIELD_W'($urandom_range(0, 3_000_000));
                lo = FIELD_W'($urandom_range(1, 3_000_000));
            end
            default:
            begin
                hi = rand_field();
                lo = rand_field();
            end
        endcase
    endtask

    // Out of reset: convergence straight away, probe, direct guess, secant guess,
    // and the widest input difference in both directions.
    task automatic test_reset_state();
        set_idling(0);
        send_step(0, 0, 0, 0);
        send_step(100, 0, 0, 0);
        send_step(100, 0, 0, 0);
        send_step(100, 0, 0, 0);
        send_step(103, 0, 0, 0);
        send_step(110, 0, 0, 0);
        send_step(FIELD_MAX, FIELD_MIN, 0, 0);
        send_step(FIELD_MIN, FIELD_MAX, 0, 0);
        send_step(-50, 0, 0, 0);
    endtask

    task automatic test_gain_extremes();
        wait_idle(2);
        write_reg(ocs_pkg::REG_GAIN, 32'd0);
        send_step(500, 0, 0, 0);
        send_step(500, 0, 0, 0);
        send_step(7, 3, 0, 0);
        wait_idle(2);
        write_reg(ocs_pkg::REG_GAIN, 32'(20'hFFFFF));
        write_reg(ocs_pkg::REG_USE_SUPPLY, 32'd1);
        send_step(1, 0, 1_000_000_000, -1_000_000_000);
        send_step(2, 0, 1_000_000_000, -1_000_000_000);
        send_step(FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN);
        send_step(FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN);
    endtask

    // High rail below the low rail, first from the supply pins, then from the registers.
    task automatic test_inverted_rails();
        send_step(10, 0, -1000, 1000);
        send_step(-10, 0, -1000, 1000);
        send_step(0, 0, -1000, 1000);
        wait_idle(2);
        write_reg(ocs_pkg::REG_USE_SUPPLY, 32'd0);
        write_reg(ocs_pkg::REG_RAIL_HIGH, 32'(-32'sd2_000_000));
        write_reg(ocs_pkg::REG_RAIL_LOW, 32'd3_000_000);
        send_step(5, 0, 0, 0);
        send_step(5, 0, 0, 0);
    endtask

    // Repeated requests and closed follower loops let the solver settle; the rest is noise.
    task automatic test_random_phases();
        int unsigned sent;
        int unsigned kind;
        logic signed [FIELD_W-1:0] vp;
        logic signed [FIELD_W-1:0] vn;
        logic signed [FIELD_W-1:0] sh;
        logic signed [FIELD_W-1:0] sl;
        logic signed [FIELD_W-1:0] rh;
        logic signed [FIELD_W-1:0] rl;
        logic [GAIN_W-1:0] g;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle(2);
            set_idling(phase % 4);
            case (phase % 6)
                0: g = 20'd1;
                1: g = GAIN_W'($urandom_range(2, 20));
                2: g = 20'd1000;
                3: g = 20'd1_000_000;
                4: g = 20'hFFFFF;
                default: g = GAIN_W'($urandom);
            endcase
            write_reg(ocs_pkg::REG_GAIN, 32'(g));
            write_reg(ocs_pkg::REG_USE_SUPPLY, 32'(phase % 3 == 1));
            pick_rails((phase + phase / 4) % 4, rh, rl);
            write_reg(ocs_pkg::REG_RAIL_HIGH, 32'(rh));
            write_reg(ocs_pkg::REG_RAIL_LOW, 32'(rl));
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                pick_rails($urandom_range(0, 3), sh, sl);
                vp = pick_voltage();
                vn = pick_voltage();
                kind = $urandom_range(0, 99);
                if (kind < 35)
                begin
                    repeat ($urandom_range(2, 6))
                    begin
                        send_step(FIELD_W'(vp + small_jitter()), vn, sh, sl);
                        sent++;
                    end
                end
                else if (kind < 65)
                begin
                    // The inverting input follows the output, as in a unity feedback loop.
                    repeat ($urandom_range(4, 12))
                    begin
                        send_step(vp, FIELD_W'(last_drive + small_jitter()), sh, sl);
                        sent++;
                    end
                end
                else if (kind < 85)
                begin
                    send_step(rand_span(2000), rand_span(2000), sh, sl);
                    sent++;
                end
                else
                begin
                    send_step(rand_field(), rand_field(), rand_field(), rand_field());
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        v_plus      = '0;
        v_minus     = '0;
        supply_high = '0;
        supply_low  = '0;
        out_ready   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_gain_extremes();
        test_inverted_rails();
        test_random_phases();

        wait_idle(DRAIN_CYCLES);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
